### hw/rtl/dtc_pkg.sv
// ----------------------------------------------------------------------------
// Dispersion tensor core package
// Default widths, multiplier chunk size and register indexes.
// ----------------------------------------------------------------------------
package dtc_pkg;

   localparam int DEF_DATA_WIDTH = 48;
   localparam int DEF_FRAC_BITS  = 32;

   // multiplier operand slice taken per pipeline stage
   localparam int MUL_CHUNK = 16;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_LONG  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_TRANS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MESH_DIMS  = 2'd2;

   localparam logic [1:0] MESH_DIMS_RESET = 2'd3;

endpackage

### hw/rtl/dispersion_tensor_calc_core.sv
// ----------------------------------------------------------------------------
// Dispersion tensor calculation core
// Streams velocity beats in and returns the six components of the symmetric
// hydrodynamic dispersion tensor, saturated signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one velocity, element dimension and diffusion per beat;
//   rsp_* returns d_xx..d_xy for it, in order. csr_* writes aL, aT and the
//   mesh dimension, only while no beat is in flight: a user duty, unchecked.
// Throughput: one beat per cycle unless rsp_stall holds the pipeline.
// Depth: chiefly the one-bit-per-stage square root and the one-bit-per-stage
//   divider, plus the 16-bit sliced multiplier stages.
// Stall: the pipeline holds while rsp_stall keeps a result in the output
//   register and the stage ahead of it is full; an empty stage there lets
//   one more beat move up, so req_stall rises only when both are occupied.
// Reset: clears all valid bits, aL and aT to zero, mesh dimension to 3.
// ----------------------------------------------------------------------------
module dispersion_tensor_calc_core
   import dtc_pkg::*;
#(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_vel_x,
   input  logic signed [DATA_WIDTH-1:0] req_vel_y,
   input  logic signed [DATA_WIDTH-1:0] req_vel_z,
   input  logic [1:0]                   req_elem_dims,
   input  logic [DATA_WIDTH-2:0]        req_diff_factor,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_d_xx,
   output logic signed [DATA_WIDTH-1:0] rsp_d_yy,
   output logic signed [DATA_WIDTH-1:0] rsp_d_zz,
   output logic signed [DATA_WIDTH-1:0] rsp_d_yz,
   output logic signed [DATA_WIDTH-1:0] rsp_d_xz,
   output logic signed [DATA_WIDTH-1:0] rsp_d_xy,

   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [DATA_WIDTH-2:0]        csr_wdata
);

   localparam int W   = DATA_WIDTH;
   localparam int AW  = W - 1;
   localparam int CH  = MUL_CHUNK;
   localparam int PW  = 2 * W;
   localparam int SW  = 2 * W + 2;
   localparam int NW  = AW + SW;
   localparam int RMW = W + 3;
   localparam int NS1 = (W + CH - 1) / CH;
   localparam int NS2 = (SW + CH - 1) / CH;

   localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MinMag = {1'b1, {(W-1){1'b0}}};

   // products: xx, yy, zz, yz, xz, xy
   localparam int PA [6] = '{0, 1, 2, 1, 0, 0};
   localparam int PB [6] = '{0, 1, 2, 2, 2, 1};

   typedef struct packed {
      logic [2:0]    neg;
      logic [1:0]    elem;
      logic [AW-1:0] dif;
   } side_type;

   typedef struct packed {
      logic                vld;
      side_type            sd;
      logic [2:0][W-1:0]   mag;
      logic [5:0][PW-1:0]  acc;
   } mp_type;

   typedef struct packed {
      logic                vld;
      side_type            sd;
      logic                zero;
      logic [SW-1:0]       s;
      logic [5:0][PW-1:0]  p;
   } sm_type;

   typedef struct packed {
      logic                vld;
      side_type            sd;
      logic                zero;
      logic [SW-1:0]       s;
      logic [5:0][PW-1:0]  p;
      logic [2*W-1:0]      src;
      logic [RMW-1:0]      rem;
      logic [W-1:0]        root;
   } rt_type;

   typedef struct packed {
      logic                vld;
      side_type            sd;
      logic                zero;
      logic [W-1:0]        root;
      logic [6:0][SW-1:0]  b;
      logic [6:0][NW-1:0]  acc;
   } ml_type;

   typedef struct packed {
      logic                vld;
      side_type            sd;
      logic                zero;
      logic [2:0]          sgn;
      logic [W-1:0]        root;
      logic [5:0][NW-1:0]  nn;
   } nm_type;

   typedef struct packed {
      logic                vld;
      side_type            sd;
      logic                zero;
      logic [2:0]          sgn;
      logic [W-1:0]        root;
      logic [5:0]          ov;
      logic [5:0][W-1:0]   rem;
      logic [5:0][W-1:0]   low;
      logic [5:0][W-1:0]   q;
   } dv_type;

   // configuration
   logic [AW-1:0] disp_long_ff;
   logic [AW-1:0] disp_trans_ff;
   logic [1:0]    mesh_dims_ff;
   logic          aneg;
   logic [AW-1:0] am;

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_long_ff  <= '0;
         disp_trans_ff <= '0;
         mesh_dims_ff  <= MESH_DIMS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DISP_LONG:  disp_long_ff  <= csr_wdata;
            CSR_DISP_TRANS: disp_trans_ff <= csr_wdata;
            CSR_MESH_DIMS:  mesh_dims_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign aneg = disp_long_ff < disp_trans_ff;
   assign am   = aneg ? (disp_trans_ff - disp_long_ff) : (disp_long_ff - disp_trans_ff);

   // pipeline registers
   mp_type in_ff, in_in;
   mp_type mp_ff [NS1];
   mp_type mp_in [NS1];
   sm_type sm_ff, sm_in;
   rt_type rt_ff [W];
   rt_type rt_in [W];
   ml_type ml_ff [NS2];
   ml_type ml_in [NS2];
   nm_type nm_ff, nm_in;
   dv_type dvp_ff, dvp_in;
   dv_type dv_ff [W];
   dv_type dv_in [W];

   logic pipe_en;
   logic out_en;

   assign out_en    = !rsp_valid || !rsp_stall;
   assign pipe_en   = out_en || !dv_ff[W-1].vld;
   assign req_stall = !pipe_en;

   // input stage: sign and magnitude
   always_comb begin
      in_in          = '0;
      in_in.vld      = req_valid;
      in_in.sd.neg   = {req_vel_z[W-1], req_vel_y[W-1], req_vel_x[W-1]};
      in_in.sd.elem  = req_elem_dims;
      in_in.sd.dif   = req_diff_factor;
      in_in.mag[0]   = req_vel_x[W-1] ? W'(-req_vel_x) : W'(req_vel_x);
      in_in.mag[1]   = req_vel_y[W-1] ? W'(-req_vel_y) : W'(req_vel_y);
      in_in.mag[2]   = req_vel_z[W-1] ? W'(-req_vel_z) : W'(req_vel_z);
   end

   // squares and cross products, one slice per stage
   for (genvar j = 0; j < NS1; j++) begin : g_mul1
      mp_type cur;
      if (j == 0) begin : g_first
         assign cur = in_ff;
      end else begin : g_next
         assign cur = mp_ff[j-1];
      end
      always_comb begin
         logic [W+CH-1:0] pp;
         mp_in[j] = cur;
         for (int k = 0; k < 6; k++) begin
            pp = cur.mag[PA[k]] * CH'(cur.mag[PB[k]] >> (j * CH));
            mp_in[j].acc[k] = cur.acc[k] + (PW'(pp) << (j * CH));
         end
      end
   end

   // sum of squares
   always_comb begin
      sm_in      = '0;
      sm_in.vld  = mp_ff[NS1-1].vld;
      sm_in.sd   = mp_ff[NS1-1].sd;
      sm_in.zero = ~|mp_ff[NS1-1].mag;
      sm_in.s    = SW'(mp_ff[NS1-1].acc[0]) + SW'(mp_ff[NS1-1].acc[1])
                 + SW'(mp_ff[NS1-1].acc[2]);
      sm_in.p    = mp_ff[NS1-1].acc;
   end

   // integer square root, one root bit per stage
   for (genvar j = 0; j < W; j++) begin : g_sqrt
      rt_type cur;
      if (j == 0) begin : g_first
         always_comb begin
            cur      = '0;
            cur.vld  = sm_ff.vld;
            cur.sd   = sm_ff.sd;
            cur.zero = sm_ff.zero;
            cur.s    = sm_ff.s;
            cur.p    = sm_ff.p;
            cur.src  = sm_ff.s[2*W-1:0];
         end
      end else begin : g_next
         assign cur = rt_ff[j-1];
      end
      always_comb begin
         logic [RMW-1:0] r2;
         logic [RMW-1:0] trial;
         r2        = {cur.rem[RMW-3:0], cur.src[2*W-1 -: 2]};
         trial     = RMW'({cur.root, 2'b01});
         rt_in[j]  = cur;
         rt_in[j].src = cur.src << 2;
         if (r2 >= trial) begin
            rt_in[j].rem  = r2 - trial;
            rt_in[j].root = {cur.root[W-2:0], 1'b1};
         end else begin
            rt_in[j].rem  = r2;
            rt_in[j].root = {cur.root[W-2:0], 1'b0};
         end
      end
   end

   // dispersivity products, one slice per stage
   for (genvar j = 0; j < NS2; j++) begin : g_mul2
      ml_type cur;
      if (j == 0) begin : g_first
         always_comb begin
            cur      = '0;
            cur.vld  = rt_ff[W-1].vld;
            cur.sd   = rt_ff[W-1].sd;
            cur.zero = rt_ff[W-1].zero;
            cur.root = rt_ff[W-1].root;
            for (int k = 0; k < 6; k++) begin
               cur.b[k] = SW'(rt_ff[W-1].p[k]);
            end
            cur.b[6] = rt_ff[W-1].s;
         end
      end else begin : g_next
         assign cur = ml_ff[j-1];
      end
      always_comb begin
         logic [AW-1:0]    a;
         logic [AW+CH-1:0] pp;
         ml_in[j] = cur;
         for (int k = 0; k < 7; k++) begin
            a  = (k < 6) ? am : disp_trans_ff;
            pp = a * CH'(cur.b[k] >> (j * CH));
            ml_in[j].acc[k] = cur.acc[k] + (NW'(pp) << (j * CH));
         end
      end
   end

   // numerators: diagonal aT*S +/- |aL-aT|*vi^2, then drop the fraction bits
   always_comb begin
      logic [NW-1:0] n;
      nm_in      = '0;
      nm_in.vld  = ml_ff[NS2-1].vld;
      nm_in.sd   = ml_ff[NS2-1].sd;
      nm_in.zero = ml_ff[NS2-1].zero;
      nm_in.root = ml_ff[NS2-1].root;
      nm_in.sgn  = {aneg ^ ml_ff[NS2-1].sd.neg[0] ^ ml_ff[NS2-1].sd.neg[1],
                    aneg ^ ml_ff[NS2-1].sd.neg[0] ^ ml_ff[NS2-1].sd.neg[2],
                    aneg ^ ml_ff[NS2-1].sd.neg[1] ^ ml_ff[NS2-1].sd.neg[2]};
      for (int i = 0; i < 3; i++) begin
         n = aneg ? (ml_ff[NS2-1].acc[6] - ml_ff[NS2-1].acc[i])
                  : (ml_ff[NS2-1].acc[6] + ml_ff[NS2-1].acc[i]);
         nm_in.nn[i] = n >> FRAC_BITS;
      end
      for (int k = 3; k < 6; k++) begin
         nm_in.nn[k] = ml_ff[NS2-1].acc[k] >> FRAC_BITS;
      end
   end

   // divider set-up: overflow check on the upper part
   always_comb begin
      dvp_in      = '0;
      dvp_in.vld  = nm_ff.vld;
      dvp_in.sd   = nm_ff.sd;
      dvp_in.zero = nm_ff.zero;
      dvp_in.sgn  = nm_ff.sgn;
      dvp_in.root = nm_ff.root;
      for (int k = 0; k < 6; k++) begin
         dvp_in.ov[k]  = nm_ff.nn[k][NW-1:W] >= (NW-W)'(nm_ff.root);
         dvp_in.rem[k] = nm_ff.nn[k][2*W-1:W];
         dvp_in.low[k] = nm_ff.nn[k][W-1:0];
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < W; j++) begin : g_div
      dv_type cur;
      if (j == 0) begin : g_first
         assign cur = dvp_ff;
      end else begin : g_next
         assign cur = dv_ff[j-1];
      end
      always_comb begin
         logic [W:0] r;
         logic [W:0] m;
         m        = {1'b0, cur.root};
         dv_in[j] = cur;
         for (int k = 0; k < 6; k++) begin
            r = {cur.rem[k], cur.low[k][W-1]};
            dv_in[j].low[k] = cur.low[k] << 1;
            if (r >= m) begin
               dv_in[j].rem[k] = W'(r - m);
               dv_in[j].q[k]   = {cur.q[k][W-2:0], 1'b1};
            end else begin
               dv_in[j].rem[k] = r[W-1:0];
               dv_in[j].q[k]   = {cur.q[k][W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.vld  <= 1'b0;
         sm_ff.vld  <= 1'b0;
         nm_ff.vld  <= 1'b0;
         dvp_ff.vld <= 1'b0;
         for (int j = 0; j < NS1; j++) mp_ff[j].vld <= 1'b0;
         for (int j = 0; j < W; j++)   rt_ff[j].vld <= 1'b0;
         for (int j = 0; j < NS2; j++) ml_ff[j].vld <= 1'b0;
         for (int j = 0; j < W; j++)   dv_ff[j].vld <= 1'b0;
      end else if (pipe_en) begin
         in_ff  <= in_in;
         sm_ff  <= sm_in;
         nm_ff  <= nm_in;
         dvp_ff <= dvp_in;
         for (int j = 0; j < NS1; j++) mp_ff[j] <= mp_in[j];
         for (int j = 0; j < W; j++)   rt_ff[j] <= rt_in[j];
         for (int j = 0; j < NS2; j++) ml_ff[j] <= ml_in[j];
         for (int j = 0; j < W; j++)   dv_ff[j] <= dv_in[j];
      end
   end

   // saturation, diffusion and dimension rules
   logic             rsp_valid_ff;
   logic [5:0][W-1:0] res_ff;
   logic [5:0][W-1:0] res_in;

   always_comb begin
      dv_type        t;
      logic [W-1:0]  qc;
      logic [W-1:0]  sum;
      logic [W-1:0]  dif;
      logic [2:0][W-1:0] dg;
      logic          yy_ok;
      logic          zz_ok;
      t     = dv_ff[W-1];
      dif   = W'(t.sd.dif);
      yy_ok = (mesh_dims_ff >= t.sd.elem) && (t.sd.elem > 2'd1);
      zz_ok = (t.sd.elem == mesh_dims_ff) && (t.sd.elem > 2'd2);
      for (int i = 0; i < 3; i++) begin
         qc    = (t.ov[i] || t.q[i] > MaxPos) ? MaxPos : t.q[i];
         sum   = qc + dif;
         dg[i] = t.zero ? dif : ((sum > MaxPos) ? MaxPos : sum);
      end
      res_in[0] = dg[0];
      res_in[1] = (t.zero || yy_ok) ? dg[1] : '0;
      res_in[2] = (t.zero || zz_ok) ? dg[2] : '0;
      for (int k = 0; k < 3; k++) begin
         if (t.zero) begin
            res_in[3+k] = '0;
         end else if (t.sgn[k]) begin
            qc          = (t.ov[3+k] || t.q[3+k] > MinMag) ? MinMag : t.q[3+k];
            res_in[3+k] = -qc;
         end else begin
            res_in[3+k] = (t.ov[3+k] || t.q[3+k] > MaxPos) ? MaxPos : t.q[3+k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= dv_ff[W-1].vld;
         res_ff       <= res_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_d_xx  = res_ff[0];
   assign rsp_d_yy  = res_ff[1];
   assign rsp_d_zz  = res_ff[2];
   assign rsp_d_yz  = res_ff[3];
   assign rsp_d_xz  = res_ff[4];
   assign rsp_d_xy  = res_ff[5];

endmodule
